// ===== rtl/core/spg_pkg.sv =====
package spg_pkg;

  // Number of motors served by the block.
  localparam int unsigned MOTORS = 6;
  // Bits needed to address one motor entry.
  localparam int unsigned MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  // Width of the reported line fields.
  localparam int unsigned LINE_W = 6;

  localparam int unsigned STEPS_W = 18;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned SEL_W   = 3;

  // Action codes of a command word; the fourth code leaves the state alone.
  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // Per-motor state as it is held in the motor RAM.
  typedef struct packed {
    logic signed [STEPS_W-1:0] remaining;
    logic [POS_W-1:0]          position;
    logic [DIV_W-1:0]          divider;
    logic [DIV_W-1:0]          reload;
    logic [POS_W-1:0]          lower;
    logic [POS_W-1:0]          upper;
  } motor_entry_t;

  localparam int unsigned ENTRY_W = $bits(motor_entry_t);

  // One command word as it travels through the sweep stages.
  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic [SEL_W-1:0]          motor_sel;
    logic signed [STEPS_W-1:0] steps;
    logic [DIV_W-1:0]          period;
    logic [POS_W-1:0]          min_limit;
    logic [POS_W-1:0]          max_limit;
  } cmd_t;

endpackage

// ===== rtl/core/spg_cmd_if.sv =====
interface spg_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [spg_pkg::ACT_W-1:0]           action;
  logic [spg_pkg::SEL_W-1:0]           motor_sel;
  logic signed [spg_pkg::STEPS_W-1:0]  steps;
  logic [spg_pkg::DIV_W-1:0]           period;
  logic [spg_pkg::POS_W-1:0]           min_limit;
  logic [spg_pkg::POS_W-1:0]           max_limit;

  modport source (
    output valid, action, motor_sel, steps, period, min_limit, max_limit,
    input  ready
  );
  modport sink (
    input  valid, action, motor_sel, steps, period, min_limit, max_limit,
    output ready
  );
endinterface

// ===== rtl/core/spg_res_if.sv =====
interface spg_res_if;
  logic                              valid;
  logic                              ready;
  logic [spg_pkg::LINE_W-1:0]        step_lines;
  logic [spg_pkg::LINE_W-1:0]        dir_lines;
  logic                              all_idle;
  logic [spg_pkg::POS_W-1:0]         position;

  modport source (
    output valid, step_lines, dir_lines, all_idle, position,
    input  ready
  );
  modport sink (
    input  valid, step_lines, dir_lines, all_idle, position,
    output ready
  );
endinterface

// ===== rtl/core/spg_cfg_if.sv =====
interface spg_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

// ===== rtl/core/spg_ram.sv =====
module spg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/stepper_pulse_generator_unit.sv =====
// Step and direction pulse generator for a bank of stepper motors.
// cmd_i takes one command word per handshake: a tick, a load of one motor's
// steps, period and soft limits, or a clear of all motors. res_o returns one
// word per command with the step and direction line levels, an all-idle flag
// and the position of the motor named by motor_sel, taken after the update.
// cfg_i writes the count mode bit and is always ready. The user must see that it
// is written only while no command is in flight; the block does not enforce this.
// Each command sweeps the motor RAM one motor per cycle while the sweep is
// not held, reading an entry in the issue stage and writing it back from
// the update stage. A new word is taken while the issue stage reads the last
// motor of the previous one; the result is loaded with the last write-back.
// The result sits in an output register; the next command is accepted while
// it waits. If the receiver stalls and a second result is ready, the sweep
// freezes on its last motor until the output register frees up.
// Reset clears the line levels, the count mode and the per-entry written
// bits, so every motor reads as all zero until its first write.
module stepper_pulse_generator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  spg_cmd_if.sink   cmd_i,
  spg_cfg_if.sink   cfg_i,
  spg_res_if.source res_o
);

  localparam logic [spg_pkg::MIDX_W-1:0] LAST_M = spg_pkg::MIDX_W'(spg_pkg::MOTORS - 1);

  // Issue stage: the command being swept and the motor read this cycle.
  logic                        s0_valid_q, s0_valid_d;
  logic [spg_pkg::MIDX_W-1:0]  s0_cnt_q, s0_cnt_d;
  spg_pkg::cmd_t               s0_item_q, s0_item_d;

  // Update stage: the motor whose RAM data is arriving this cycle.
  logic                        s1_valid_q, s1_valid_d;
  logic [spg_pkg::MIDX_W-1:0]  s1_m_q, s1_m_d;
  spg_pkg::cmd_t               s1_item_q, s1_item_d;

  // Motor line levels and per-motor flags.
  logic [spg_pkg::MOTORS-1:0]  step_q, step_d;
  logic [spg_pkg::MOTORS-1:0]  dir_q, dir_d;
  logic [spg_pkg::MOTORS-1:0]  half_q, half_d;
  logic [spg_pkg::MOTORS-1:0]  busy_q, busy_d;
  logic [spg_pkg::MOTORS-1:0]  written_q, written_d;
  logic                        count_mode_q, count_mode_d;
  logic [spg_pkg::POS_W-1:0]   pos_cap_q, pos_cap_d;

  // RAM read side with written bit and forwarding.
  logic                        rd_written_q, rd_written_d;
  logic                        fwd_q, fwd_d;
  spg_pkg::motor_entry_t       fwd_data_q, fwd_data_d;
  logic [spg_pkg::ENTRY_W-1:0] ram_rdata;

  // Output register.
  logic                        res_valid_q, res_valid_d;
  logic [spg_pkg::LINE_W-1:0]  res_step_q, res_step_d;
  logic [spg_pkg::LINE_W-1:0]  res_dir_q, res_dir_d;
  logic                        res_idle_q, res_idle_d;
  logic [spg_pkg::POS_W-1:0]   res_pos_q, res_pos_d;

  logic                        hold;
  logic                        s0_last;
  logic                        s1_last;
  logic                        accept;
  logic                        ram_re;
  logic                        ram_we;
  spg_pkg::motor_entry_t       cur;
  spg_pkg::motor_entry_t       nxt;
  logic                        sel_hit;
  logic                        sel_ok;

  // Handshake and stall control.
  assign s0_last     = (s0_cnt_q == LAST_M);
  assign s1_last     = (s1_m_q == LAST_M);
  assign hold        = s1_valid_q && s1_last && res_valid_q && !res_o.ready;
  assign cmd_i.ready = !hold && (!s0_valid_q || s0_last);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;
  assign ram_re      = s0_valid_q && !hold;
  assign ram_we      = s1_valid_q && !hold;

  // Motor state memory.
  spg_ram #(
    .WIDTH (spg_pkg::ENTRY_W),
    .DEPTH (spg_pkg::MOTORS)
  ) u_motor_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_m_q),
    .wdata_i (nxt),
    .re_i    (ram_re),
    .raddr_i (s0_cnt_q),
    .rdata_o (ram_rdata)
  );

  // Sweep stage sequencing.
  always_comb begin
    s0_valid_d = s0_valid_q;
    s0_cnt_d   = s0_cnt_q;
    s0_item_d  = s0_item_q;
    if (accept) begin
      s0_valid_d = 1'b1;
      s0_cnt_d   = '0;
      s0_item_d  = '{
        action:    cmd_i.action,
        motor_sel: cmd_i.motor_sel,
        steps:     cmd_i.steps,
        period:    cmd_i.period,
        min_limit: cmd_i.min_limit,
        max_limit: cmd_i.max_limit
      };
    end else if (s0_valid_q && !hold) begin
      if (s0_last) begin
        s0_valid_d = 1'b0;
      end else begin
        s0_cnt_d = s0_cnt_q + 1'b1;
      end
    end

    s1_valid_d = s1_valid_q;
    s1_m_d     = s1_m_q;
    s1_item_d  = s1_item_q;
    if (!hold) begin
      s1_valid_d = s0_valid_q;
      s1_m_d     = s0_cnt_q;
      s1_item_d  = s0_item_q;
    end
  end

  // Read-side bookkeeping: entries never written read as zero, and a read
  // of the entry being written in the same cycle takes the new data.
  always_comb begin
    rd_written_d = rd_written_q;
    fwd_d        = fwd_q;
    fwd_data_d   = fwd_data_q;
    written_d    = written_q;
    if (ram_re) begin
      rd_written_d = written_q[s0_cnt_q];
      fwd_d        = ram_we && (s1_m_q == s0_cnt_q);
      fwd_data_d   = nxt;
    end
    if (ram_we) begin
      written_d[s1_m_q] = 1'b1;
    end
  end

  always_comb begin
    if (fwd_q) begin
      cur = fwd_data_q;
    end else if (rd_written_q) begin
      cur = spg_pkg::motor_entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  assign sel_hit = (spg_pkg::SEL_W'(s1_m_q) == s1_item_q.motor_sel);
  assign sel_ok  = ({1'b0, s1_item_q.motor_sel} < (spg_pkg::SEL_W + 1)'(spg_pkg::MOTORS));

  // Per-motor update for the current command.
  always_comb begin
    logic [spg_pkg::DIV_W-1:0] div_dec;
    logic                      fire;
    logic                      in_lim;
    logic                      at_edge;
    logic                      move;
    logic                      up;

    nxt     = cur;
    step_d  = step_q;
    dir_d   = dir_q;
    half_d  = half_q;
    div_dec = cur.divider - 1'b1;
    fire    = (div_dec == '0) && (cur.remaining != '0);
    up      = (cur.remaining > 0);
    in_lim  = (cur.lower < cur.position) && (cur.position < cur.upper);
    at_edge = ((cur.position == cur.lower) && up) ||
              ((cur.position != cur.lower) && (cur.position == cur.upper) &&
               (cur.remaining < 0));
    move    = 1'b0;

    if (ram_we) begin
      case (s1_item_q.action)
        spg_pkg::ACT_TICK: begin
          if (fire) begin
            dir_d[s1_m_q] = !up;
            nxt.divider   = cur.reload;
            if (in_lim || at_edge) begin
              step_d[s1_m_q] = !step_q[s1_m_q];
              half_d[s1_m_q] = !half_q[s1_m_q];
              move = in_lim ? !half_q[s1_m_q] : half_q[s1_m_q];
            end
          end else begin
            nxt.divider = div_dec;
            if (cur.remaining == '0) begin
              step_d[s1_m_q] = 1'b0;
            end
          end
          if (move) begin
            if (up) begin
              if (cur.position != '1) begin
                nxt.position = cur.position + 1'b1;
              end
              if (count_mode_q) begin
                nxt.remaining = cur.remaining - 1'b1;
              end
            end else begin
              if (cur.position != '0) begin
                nxt.position = cur.position - 1'b1;
              end
              if (count_mode_q) begin
                nxt.remaining = cur.remaining + 1'b1;
              end
            end
          end
        end
        spg_pkg::ACT_LOAD: begin
          if (sel_hit) begin
            nxt.remaining = s1_item_q.steps;
            nxt.reload    = s1_item_q.period;
            nxt.divider   = s1_item_q.period;
            nxt.lower     = s1_item_q.min_limit;
            nxt.upper     = s1_item_q.max_limit;
          end
        end
        spg_pkg::ACT_CLEAR: begin
          nxt.remaining = '0;
          nxt.position  = '0;
          nxt.divider   = '0;
          nxt.reload    = '0;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  // Remaining-steps flags, reported position and the result word.
  always_comb begin
    busy_d      = busy_q;
    pos_cap_d   = pos_cap_q;
    res_valid_d = res_valid_q;
    res_step_d  = res_step_q;
    res_dir_d   = res_dir_q;
    res_idle_d  = res_idle_q;
    res_pos_d   = res_pos_q;

    if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (ram_we) begin
      busy_d[s1_m_q] = (nxt.remaining != '0);
      if (sel_hit) begin
        pos_cap_d = nxt.position;
      end else if (s1_m_q == '0) begin
        pos_cap_d = '0;
      end
      if (s1_last) begin
        res_valid_d = 1'b1;
        res_idle_d  = (busy_d == '0);
        res_pos_d   = sel_ok ? pos_cap_d : '0;
        for (int i = 0; i < int'(spg_pkg::LINE_W); i++) begin
          if (i < int'(spg_pkg::MOTORS)) begin
            res_step_d[i] = step_d[i];
            res_dir_d[i]  = dir_d[i];
          end else begin
            res_step_d[i] = 1'b0;
            res_dir_d[i]  = 1'b0;
          end
        end
      end
    end
  end

  // Count mode register.
  assign count_mode_d = cfg_i.valid ? cfg_i.data : count_mode_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q   <= 1'b0;
      s0_cnt_q     <= '0;
      s1_valid_q   <= 1'b0;
      s1_m_q       <= '0;
      step_q       <= '0;
      dir_q        <= '0;
      half_q       <= '0;
      busy_q       <= '0;
      written_q    <= '0;
      count_mode_q <= 1'b0;
      rd_written_q <= 1'b0;
      fwd_q        <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      s0_valid_q   <= s0_valid_d;
      s0_cnt_q     <= s0_cnt_d;
      s1_valid_q   <= s1_valid_d;
      s1_m_q       <= s1_m_d;
      step_q       <= step_d;
      dir_q        <= dir_d;
      half_q       <= half_d;
      busy_q       <= busy_d;
      written_q    <= written_d;
      count_mode_q <= count_mode_d;
      rd_written_q <= rd_written_d;
      fwd_q        <= fwd_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s0_item_q  <= s0_item_d;
    s1_item_q  <= s1_item_d;
    fwd_data_q <= fwd_data_d;
    pos_cap_q  <= pos_cap_d;
    res_step_q <= res_step_d;
    res_dir_q  <= res_dir_d;
    res_idle_q <= res_idle_d;
    res_pos_q  <= res_pos_d;
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.step_lines = res_step_q;
  assign res_o.dir_lines  = res_dir_q;
  assign res_o.all_idle   = res_idle_q;
  assign res_o.position   = res_pos_q;

endmodule
